[design/dqvs_pkg.sv]
// ----------------------------------------------------------------------------
// dqvs_pkg - shared types and constants for the deque with value search
// Store geometry, operation and status codes, sequencer states and the
// circular index helper.
// ----------------------------------------------------------------------------
package dqvs_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = PTR_W + 1;
  localparam int KIND_W = 3;
  localparam int STAT_W = 3;
  localparam int POS_W  = 7;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH_FRONT = 3'd0,
    K_PUSH_BACK  = 3'd1,
    K_POP_FRONT  = 3'd2,
    K_POP_BACK   = 3'd3,
    K_SEARCH     = 3'd4,
    K_SHOW       = 3'd5
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FOUND     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK
  } state_e;

  // (base + off) mod DEPTH, both operands below DEPTH
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [PTR_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

[design/deque_with_value_search.sv]
// ----------------------------------------------------------------------------
// deque_with_value_search - bounded double-ended queue with linear search
// Circular element store with push/pop at both ends, a front-to-back search
// and a show walk that streams every stored element.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one operation per beat:
//   kind_i selects push front/back, pop front/back, search or show, value_i
//   is the element pushed or the key searched for. Codes 6 and 7 are taken
//   and dropped without a result.
//   Output channel (out_valid_o/out_ready_i) returns status_o, position_o,
//   element_o and last_o; last_o marks the final beat of an operation.
//   Push, pop and any operation on an empty store: result registered in the
//   cycle after the input beat; a new beat is taken every cycle while the
//   receiver keeps up.
//   Search and show: the store has one registered read port and the walk
//   visits each entry in S_READ, then S_CHECK (read, then compare or emit),
//   covering up to DEPTH entries. The block takes no new beat until the
//   walk is over.
//   A stalled receiver holds the output register; the walk waits on it.
//   Reset empties the queue at once (front index and occupancy cleared);
//   store contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module deque_with_value_search (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [dqvs_pkg::KIND_W-1:0]          kind_i,
  input  logic signed [dqvs_pkg::DATA_W-1:0]   value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [dqvs_pkg::STAT_W-1:0]          status_o,
  output logic [dqvs_pkg::POS_W-1:0]           position_o,
  output logic signed [dqvs_pkg::DATA_W-1:0]   element_o,
  output logic                                 last_o
);

  dqvs_pkg::state_e                state_q, state_d;
  logic [dqvs_pkg::PTR_W-1:0]      front_q, front_d;
  logic [dqvs_pkg::CNT_W-1:0]      occ_q, occ_d;
  logic [dqvs_pkg::PTR_W-1:0]      idx_q, idx_d;
  logic [dqvs_pkg::DATA_W-1:0]     key_q, key_d;
  logic                            show_q, show_d;

  logic                            ov_q, ov_d;
  logic [dqvs_pkg::STAT_W-1:0]     status_q, status_d;
  logic [dqvs_pkg::POS_W-1:0]      pos_q, pos_d;
  logic [dqvs_pkg::DATA_W-1:0]     elem_q, elem_d;
  logic                            last_q, last_d;

  logic [dqvs_pkg::DATA_W-1:0]     mem [dqvs_pkg::DEPTH];
  logic [dqvs_pkg::DATA_W-1:0]     rd_data_q;
  logic                            mem_we, rd_en;
  logic [dqvs_pkg::PTR_W-1:0]      mem_wa, rd_addr;

  logic                            out_free, in_acc, last_ent, full, empty;
  logic [dqvs_pkg::CNT_W-1:0]      idx_next;

  assign out_free = ~ov_q | out_ready_i;
  assign in_acc   = in_valid_i & in_ready_o;
  assign full     = (occ_q == dqvs_pkg::CNT_W'(dqvs_pkg::DEPTH));
  assign empty    = (occ_q == '0);
  assign idx_next = {1'b0, idx_q} + dqvs_pkg::CNT_W'(1);
  assign last_ent = (idx_next == occ_q);
  assign rd_addr  = dqvs_pkg::wrap_add(front_q, idx_q);

  always_comb begin
    state_d    = state_q;
    front_d    = front_q;
    occ_d      = occ_q;
    idx_d      = idx_q;
    key_d      = key_q;
    show_d     = show_q;
    ov_d       = ov_q & ~out_ready_i;
    status_d   = status_q;
    pos_d      = pos_q;
    elem_d     = elem_q;
    last_d     = last_q;
    mem_we     = 1'b0;
    mem_wa     = front_q;
    rd_en      = 1'b0;
    in_ready_o = 1'b0;

    unique case (state_q)
      dqvs_pkg::S_IDLE: begin
        in_ready_o = out_free;
        if (in_acc) begin
          // single-beat results share these defaults
          status_d = dqvs_pkg::ST_DONE;
          pos_d    = '0;
          elem_d   = '0;
          last_d   = 1'b1;
          unique case (kind_i)
            dqvs_pkg::K_PUSH_FRONT: begin
              ov_d = 1'b1;
              if (full) begin
                status_d = dqvs_pkg::ST_FULL;
              end else begin
                front_d = (front_q == '0) ? dqvs_pkg::PTR_W'(dqvs_pkg::DEPTH - 1)
                                          : front_q - dqvs_pkg::PTR_W'(1);
                mem_we  = 1'b1;
                mem_wa  = front_d;
                occ_d   = occ_q + dqvs_pkg::CNT_W'(1);
              end
            end
            dqvs_pkg::K_PUSH_BACK: begin
              ov_d = 1'b1;
              if (full) begin
                status_d = dqvs_pkg::ST_FULL;
              end else begin
                mem_we = 1'b1;
                mem_wa = dqvs_pkg::wrap_add(front_q, occ_q[dqvs_pkg::PTR_W-1:0]);
                occ_d  = occ_q + dqvs_pkg::CNT_W'(1);
              end
            end
            dqvs_pkg::K_POP_FRONT: begin
              ov_d = 1'b1;
              if (empty) begin
                status_d = dqvs_pkg::ST_EMPTY;
              end else begin
                front_d = dqvs_pkg::wrap_add(front_q, dqvs_pkg::PTR_W'(1));
                occ_d   = occ_q - dqvs_pkg::CNT_W'(1);
              end
            end
            dqvs_pkg::K_POP_BACK: begin
              ov_d = 1'b1;
              if (empty) begin
                status_d = dqvs_pkg::ST_EMPTY;
              end else begin
                occ_d = occ_q - dqvs_pkg::CNT_W'(1);
              end
            end
            dqvs_pkg::K_SEARCH, dqvs_pkg::K_SHOW: begin
              if (empty) begin
                ov_d     = 1'b1;
                status_d = dqvs_pkg::ST_EMPTY;
              end else begin
                key_d   = value_i;
                show_d  = (kind_i == dqvs_pkg::K_SHOW);
                idx_d   = '0;
                state_d = dqvs_pkg::S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      dqvs_pkg::S_READ: begin
        rd_en   = 1'b1;
        state_d = dqvs_pkg::S_CHECK;
      end
      dqvs_pkg::S_CHECK: begin
        if (show_q) begin
          if (out_free) begin
            ov_d     = 1'b1;
            status_d = dqvs_pkg::ST_DONE;
            pos_d    = dqvs_pkg::POS_W'(idx_next);
            elem_d   = rd_data_q;
            last_d   = last_ent;
            if (last_ent) begin
              state_d = dqvs_pkg::S_IDLE;
            end else begin
              idx_d   = idx_next[dqvs_pkg::PTR_W-1:0];
              state_d = dqvs_pkg::S_READ;
            end
          end
        end else if (rd_data_q == key_q) begin
          if (out_free) begin
            ov_d     = 1'b1;
            status_d = dqvs_pkg::ST_FOUND;
            pos_d    = dqvs_pkg::POS_W'(idx_next);
            elem_d   = '0;
            last_d   = 1'b1;
            state_d  = dqvs_pkg::S_IDLE;
          end
        end else if (last_ent) begin
          if (out_free) begin
            ov_d     = 1'b1;
            status_d = dqvs_pkg::ST_NOT_FOUND;
            pos_d    = '0;
            elem_d   = '0;
            last_d   = 1'b1;
            state_d  = dqvs_pkg::S_IDLE;
          end
        end else begin
          idx_d   = idx_next[dqvs_pkg::PTR_W-1:0];
          state_d = dqvs_pkg::S_READ;
        end
      end
      default: state_d = dqvs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dqvs_pkg::S_IDLE;
      front_q <= '0;
      occ_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      occ_q   <= occ_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    key_q    <= key_d;
    show_q   <= show_d;
    status_q <= status_d;
    pos_q    <= pos_d;
    elem_q   <= elem_d;
    last_q   <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= value_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign out_valid_o = ov_q;
  assign status_o    = status_q;
  assign position_o  = pos_q;
  assign element_o   = elem_q;
  assign last_o      = last_q;

endmodule

[design/dqvs_checker.sv]
// ----------------------------------------------------------------------------
// dqvs_checker - port-level assertions for the deque with value search
// Watches the output channel for held beats and consistent result fields.
// ----------------------------------------------------------------------------
module dqvs_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [dqvs_pkg::STAT_W-1:0]         status_o,
  input logic [dqvs_pkg::POS_W-1:0]          position_o,
  input logic signed [dqvs_pkg::DATA_W-1:0]  element_o,
  input logic                                last_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(position_o) && $stable(element_o) && $stable(last_o))
    else $error("result beat changed while stalled");

  // only show beats can be non-final
  a_single_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != dqvs_pkg::ST_DONE |-> last_o)
    else $error("error or search status without last");

  // element only travels on show beats, which carry an index
  a_elem_show: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && element_o != '0 |->
    status_o == dqvs_pkg::ST_DONE && position_o != '0)
    else $error("element on a non-show beat");

  // found carries a position, failed searches and errors do not
  a_found_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == dqvs_pkg::ST_FOUND) == (position_o == '0) |->
    status_o == dqvs_pkg::ST_DONE)
    else $error("position inconsistent with status");

endmodule

bind deque_with_value_search dqvs_checker u_dqvs_checker (.*);

[tb/sv/deque_with_value_search_tb.sv]
// ----------------------------------------------------------------------------
// deque_with_value_search_tb - self-checking bench for the value search deque
// A shadow deque in a small scoreboard class predicts every result beat of
// push, pop, search and show. Directed corner cases come first, then random
// fill, drain and mixed phases under bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module deque_with_value_search_tb;

  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int RAND_OPS     = 330;
  localparam int HOLD_CYCLES  = 400;
  localparam int WALK_CYCLES  = 1 + 2 * dqvs_pkg::DEPTH;

  // kind codes the block drops without a result
  localparam logic [dqvs_pkg::KIND_W-1:0] KIND_RSVD_A = 3'd6;
  localparam logic [dqvs_pkg::KIND_W-1:0] KIND_RSVD_B = 3'd7;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_BOTH} mix_e;
  typedef enum {RX_OPEN, RX_COIN, RX_SLOW} rx_e;

  class deque_shadow;
    typedef struct {
      logic [dqvs_pkg::STAT_W-1:0]        status;
      logic [dqvs_pkg::POS_W-1:0]         position;
      logic signed [dqvs_pkg::DATA_W-1:0] element;
      logic                               last;
    } beat_t;

    logic signed [dqvs_pkg::DATA_W-1:0] cells [dqvs_pkg::DEPTH];
    int unsigned                        head;
    int unsigned                        fill;
    beat_t                              awaited [$];
    int                                 errors;

    function new();
      head   = 0;
      fill   = 0;
      errors = 0;
    endfunction

    function void push_beat(logic [dqvs_pkg::STAT_W-1:0] st, int unsigned pos,
                            logic signed [dqvs_pkg::DATA_W-1:0] el, logic lst);
      beat_t b;
      b.status   = st;
      b.position = dqvs_pkg::POS_W'(pos);
      b.element  = el;
      b.last     = lst;
      awaited.push_back(b);
    endfunction

    // apply one accepted operation and queue the beats it must produce
    function void take_op(logic [dqvs_pkg::KIND_W-1:0] kind,
                          logic signed [dqvs_pkg::DATA_W-1:0] value);
      int unsigned i;
      bit          hit;
      case (kind)
        dqvs_pkg::K_PUSH_FRONT, dqvs_pkg::K_PUSH_BACK: begin
          if (fill == dqvs_pkg::DEPTH) begin
            push_beat(dqvs_pkg::ST_FULL, 0, '0, 1'b1);
          end else begin
            if (kind == dqvs_pkg::K_PUSH_FRONT) begin
              head = (head + dqvs_pkg::DEPTH - 1) % dqvs_pkg::DEPTH;
              cells[head] = value;
            end else begin
              cells[(head + fill) % dqvs_pkg::DEPTH] = value;
            end
            fill++;
            push_beat(dqvs_pkg::ST_DONE, 0, '0, 1'b1);
          end
        end
        dqvs_pkg::K_POP_FRONT, dqvs_pkg::K_POP_BACK: begin
          if (fill == 0) begin
            push_beat(dqvs_pkg::ST_EMPTY, 0, '0, 1'b1);
          end else begin
            if (kind == dqvs_pkg::K_POP_FRONT) head = (head + 1) % dqvs_pkg::DEPTH;
            fill--;
            push_beat(dqvs_pkg::ST_DONE, 0, '0, 1'b1);
          end
        end
        dqvs_pkg::K_SEARCH: begin
          if (fill == 0) begin
            push_beat(dqvs_pkg::ST_EMPTY, 0, '0, 1'b1);
          end else begin
            hit = 1'b0;
            for (i = 0; i < fill && !hit; i++) begin
              if (cells[(head + i) % dqvs_pkg::DEPTH] == value) begin
                push_beat(dqvs_pkg::ST_FOUND, i + 1, '0, 1'b1);
                hit = 1'b1;
              end
            end
            if (!hit) push_beat(dqvs_pkg::ST_NOT_FOUND, 0, '0, 1'b1);
          end
        end
        dqvs_pkg::K_SHOW: begin
          if (fill == 0) begin
            push_beat(dqvs_pkg::ST_EMPTY, 0, '0, 1'b1);
          end else begin
            for (i = 0; i < fill; i++) begin
              push_beat(dqvs_pkg::ST_DONE, i + 1, cells[(head + i) % dqvs_pkg::DEPTH],
                        i + 1 == fill);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void match_result(logic [dqvs_pkg::STAT_W-1:0] st,
                               logic [dqvs_pkg::POS_W-1:0] pos,
                               logic signed [dqvs_pkg::DATA_W-1:0] el, logic lst);
      beat_t w;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected beat status %0d position %0d element %0d last %0d",
                 $time, st, pos, el, lst);
        errors++;
        return;
      end
      w = awaited.pop_front();
      if (st !== w.status) begin
        $display("%0t: status expected %0d got %0d", $time, w.status, st);
        errors++;
      end
      if (pos !== w.position) begin
        $display("%0t: position expected %0d got %0d", $time, w.position, pos);
        errors++;
      end
      if (el !== w.element) begin
        $display("%0t: element expected %0d got %0d", $time, w.element, el);
        errors++;
      end
      if (lst !== w.last) begin
        $display("%0t: last expected %0d got %0d", $time, w.last, lst);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // some element now held, so searches hit; zero when the store is empty
    function logic signed [dqvs_pkg::DATA_W-1:0] pick_held();
      if (fill == 0) return '0;
      return cells[(head + $urandom_range(0, fill - 1)) % dqvs_pkg::DEPTH];
    endfunction
  endclass

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic [dqvs_pkg::KIND_W-1:0]        kind_i;
  logic signed [dqvs_pkg::DATA_W-1:0] value_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic [dqvs_pkg::STAT_W-1:0]        status_o;
  logic [dqvs_pkg::POS_W-1:0]         position_o;
  logic signed [dqvs_pkg::DATA_W-1:0] element_o;
  logic                               last_o;

  deque_shadow                        shadow = new();
  logic signed [dqvs_pkg::DATA_W-1:0] pool [8];
  bit                                 hold_req;
  bit                                 hold_done = 1'b0;
  int                                 cycles = 0;

  deque_with_value_search dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .position_o  (position_o),
    .element_o   (element_o),
    .last_o      (last_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      shadow.match_result(status_o, position_o, element_o, last_o);
    end
  end

  // receiver: segments of open, coin-flip and slow acceptance, plus one long hold
  initial begin
    int  seg;
    int  slow_cnt;
    rx_e mode;
    out_ready_i = 1'b0;
    seg         = 0;
    slow_cnt    = 0;
    mode        = RX_OPEN;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        if (seg == 0) begin
          mode = rx_e'($urandom_range(0, 2));
          seg  = $urandom_range(20, 120);
        end
        seg--;
        case (mode)
          RX_OPEN: out_ready_i <= 1'b1;
          RX_COIN: out_ready_i <= 1'($urandom_range(0, 1));
          default: begin
            if (slow_cnt == 0) begin
              out_ready_i <= 1'b1;
              slow_cnt = $urandom_range(1, 6);
            end else begin
              out_ready_i <= 1'b0;
              slow_cnt--;
            end
          end
        endcase
      end
    end
  end

  task automatic send_op(input logic [dqvs_pkg::KIND_W-1:0] kind,
                         input logic signed [dqvs_pkg::DATA_W-1:0] value);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    shadow.take_op(kind, value);
  endtask

  task automatic idle_gap(input int n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  function automatic logic signed [dqvs_pkg::DATA_W-1:0] rand_word();
    if ($urandom_range(0, 9) < 3) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [dqvs_pkg::KIND_W-1:0] pick_kind(mix_e mix);
    int r;
    int p_push;
    int p_pop;
    int p_search;
    int p_show;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin p_push = 85; p_pop = 90; p_search = 96; p_show = 99; end
      MIX_DRAIN: begin p_push = 8;  p_pop = 88; p_search = 94; p_show = 98; end
      default:   begin p_push = 30; p_pop = 60; p_search = 80; p_show = 95; end
    endcase
    if (r < p_push) begin
      return $urandom_range(0, 1) ? dqvs_pkg::K_PUSH_BACK : dqvs_pkg::K_PUSH_FRONT;
    end
    if (r < p_pop) begin
      return $urandom_range(0, 1) ? dqvs_pkg::K_POP_BACK : dqvs_pkg::K_POP_FRONT;
    end
    if (r < p_search) return dqvs_pkg::K_SEARCH;
    if (r < p_show) return dqvs_pkg::K_SHOW;
    return $urandom_range(0, 1) ? KIND_RSVD_B : KIND_RSVD_A;
  endfunction

  initial begin
    int                                 issued;
    int                                 burst;
    int                                 phase_left;
    bit                                 paused;
    mix_e                               mix;
    logic [dqvs_pkg::KIND_W-1:0]        k;
    logic signed [dqvs_pkg::DATA_W-1:0] v;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    kind_i     = dqvs_pkg::K_PUSH_FRONT;
    value_i    = '0;
    hold_req   = 1'b0;
    pool[0] = 32'sh0000_0000;
    pool[1] = -32'sd1;
    pool[2] = 32'sh8000_0000;
    pool[3] = 32'sh7fff_ffff;
    pool[4] = 32'sd1;
    for (int i = 5; i < 8; i++) pool[i] = $urandom;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty-store errors, dropped codes, extremes, duplicate search
    send_op(dqvs_pkg::K_POP_FRONT, '0);
    send_op(dqvs_pkg::K_POP_BACK, '0);
    send_op(dqvs_pkg::K_SEARCH, '0);
    send_op(dqvs_pkg::K_SHOW, '0);
    send_op(KIND_RSVD_A, '0);
    send_op(KIND_RSVD_B, -32'sd1);
    send_op(dqvs_pkg::K_PUSH_BACK, 32'sh7fff_ffff);
    send_op(dqvs_pkg::K_PUSH_FRONT, 32'sh8000_0000);
    send_op(dqvs_pkg::K_PUSH_BACK, '0);
    send_op(dqvs_pkg::K_PUSH_FRONT, -32'sd1);
    send_op(dqvs_pkg::K_PUSH_BACK, 32'sh7fff_ffff);
    send_op(dqvs_pkg::K_SEARCH, 32'sh7fff_ffff);
    send_op(dqvs_pkg::K_SEARCH, 32'sd12345);
    send_op(dqvs_pkg::K_SEARCH, 32'sh8000_0000);
    send_op(dqvs_pkg::K_SHOW, '0);
    send_op(dqvs_pkg::K_POP_FRONT, '0);
    send_op(dqvs_pkg::K_POP_BACK, '0);
    send_op(dqvs_pkg::K_SHOW, '0);
    send_op(dqvs_pkg::K_POP_FRONT, '0);
    send_op(dqvs_pkg::K_POP_BACK, '0);
    send_op(dqvs_pkg::K_POP_BACK, '0);
    send_op(dqvs_pkg::K_POP_FRONT, '0);
    send_op(dqvs_pkg::K_PUSH_FRONT, 32'sh5555_5555);
    send_op(dqvs_pkg::K_PUSH_BACK, 32'shaaaa_aaaa);
    send_op(dqvs_pkg::K_SHOW, '0);
    idle_gap(1);
    while (shadow.pending() != 0) @(posedge clk_i);

    // random: first phase fills the store to overflow, then mixed phases
    issued     = 0;
    burst      = 0;
    paused     = 1'b0;
    mix        = MIX_FILL;
    phase_left = 110;
    while (issued < RAND_OPS) begin
      if (phase_left == 0) begin
        mix        = mix_e'($urandom_range(0, 2));
        phase_left = $urandom_range(30, 90);
      end
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
      end
      if (issued >= 150) hold_req = 1'b1;
      if (issued >= 250 && !paused) begin
        paused = 1'b1;
        idle_gap(1);
        while (shadow.pending() != 0) @(posedge clk_i);
      end
      k = pick_kind(mix);
      if (k == dqvs_pkg::K_SEARCH && $urandom_range(0, 1)) v = shadow.pick_held();
      else v = rand_word();
      send_op(k, v);
      burst--;
      phase_left--;
      if (k != KIND_RSVD_A && k != KIND_RSVD_B) issued++;
    end
    idle_gap(1);

    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (WALK_CYCLES + 4) @(posedge clk_i);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
